>>> hdl/crsc_pkg.sv
// ----------------------------------------------------------------------------
// crsc_pkg
// shared sizes and helpers for the column to row span converter
// ----------------------------------------------------------------------------
package crsc_pkg;

  // rows of the plane, and the widths that follow from it
  localparam int unsigned Rows   = 64;
  localparam int unsigned RowW   = $clog2(Rows);
  // row pointer that can also hold rows itself (empty range marker)
  localparam int unsigned RptrW  = $clog2(Rows + 1);

  // screen columns and field widths
  localparam int unsigned Columns = 512;
  localparam int unsigned ColW    = 10;
  localparam int unsigned XW      = $clog2(Columns);

  // an empty range is top = rows, bottom = 0
  localparam logic [RptrW-1:0] EmptyTop    = RptrW'(Rows);
  localparam logic [RptrW-1:0] EmptyBottom = '0;

  typedef logic [RptrW-1:0] rptr_t;

  // saturate an input row to the last row of the plane
  function automatic rptr_t clamp_row(input logic [5:0] row);
    rptr_t r;
    r = rptr_t'(row);
    if (r > rptr_t'(Rows - 1)) begin
      r = rptr_t'(Rows - 1);
    end
    return r;
  endfunction

endpackage

>>> hdl/column_to_row_span_converter_unit.sv
// ----------------------------------------------------------------------------
// column_to_row_span_converter_unit
// turns plane columns into horizontal spans, one row start column per row
// kept in a small synchronous memory
// ----------------------------------------------------------------------------
// Each input item is one screen column of a plane (column index, top and
// bottom covered row, empty flag, new-plane flag). Rows that the previous
// column covered but this one does not are closed and sent out as spans
// (row, start column, column - 1): the top-side rows first going down the
// screen, then the bottom-side rows going up; last_span marks the final
// span of an item. Rows that become covered record this column as their
// start. Every closed row costs a read of the span start memory and a
// load of the output register, every opened row costs a write, and the
// sequencer passes through each of its four phases plus the accept; the
// next item is taken only once the sequencer is back in idle.
// A closing read is only issued while the output register is free or being
// taken, so a stalled output holds the walk. The span start memory needs
// no clearing: a row is only ever read after it was opened. Feed an empty
// column after the last column of a plane so that all open spans close.
// ----------------------------------------------------------------------------
module column_to_row_span_converter_unit
  import crsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // column items
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [ColW-1:0] column_i,
  input  logic [5:0]      top_row_i,
  input  logic [5:0]      bottom_row_i,
  input  logic            empty_column_i,
  input  logic            plane_start_i,
  // span items
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [RowW-1:0] span_row_o,
  output logic [XW-1:0]   span_x_start_o,
  output logic [XW-1:0]   span_x_end_o,
  output logic            last_span_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,     // close top-side rows, ascending
    S_BOT,     // close bottom-side rows, descending
    S_FETCH,   // start column read back, load output register
    S_OTOP,    // open top-side rows
    S_OBOT     // open bottom-side rows
  } state_e;

  state_e state_q, ret_q;

  // previous column range
  logic [5:0] prev_top_q, prev_bottom_q;
  logic       prev_empty_q;

  // walking pointers: old range (t1, b1) and new range (t2, b2)
  rptr_t t1_q, b1_q, t2_q, b2_q;
  logic [ColW-1:0] col_q;
  logic [XW-1:0]   xend_q;
  logic [RowW-1:0] row_q;
  logic            last_q;

  // output register
  logic            out_valid_q;
  logic [RowW-1:0] span_row_q;
  logic [XW-1:0]   span_x_start_q, span_x_end_q;
  logic            last_span_q;

  // span start memory
  logic [ColW-1:0] span_mem [Rows];
  logic [ColW-1:0] rdata_q;
  logic            mem_re, mem_we;
  logic [RowW-1:0] mem_raddr, mem_waddr;

  logic  accept, out_free;
  logic  top_go, bot_go, otop_go, obot_go;
  logic  more_after_top, more_after_bot;
  rptr_t t1_inc, b1_dec;
  rptr_t top_in, bot_in;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign top_in = clamp_row(top_row_i);
  assign bot_in = clamp_row(bottom_row_i);

  // loop conditions of the four row walks
  assign top_go  = (t1_q < t2_q) && (t1_q <= b1_q);
  assign bot_go  = (b1_q > b2_q) && (b1_q >= t1_q);
  assign otop_go = (t2_q < t1_q) && (t2_q <= b2_q);
  assign obot_go = (b2_q > b1_q) && (b2_q >= t2_q);

  // does another close follow the one issued now
  assign t1_inc = t1_q + rptr_t'(1);
  assign b1_dec = b1_q - rptr_t'(1);
  assign more_after_top = ((t1_inc < t2_q) && (t1_inc <= b1_q)) ||
                          ((b1_q > b2_q) && (b1_q >= t1_inc));
  assign more_after_bot = (b1_dec > b2_q) && (b1_dec >= t1_q);

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = t1_q[RowW-1:0];
    mem_we    = 1'b0;
    mem_waddr = t2_q[RowW-1:0];
    case (state_q)
      S_TOP: begin
        mem_re    = top_go && out_free;
        mem_raddr = t1_q[RowW-1:0];
      end
      S_BOT: begin
        mem_re    = bot_go && out_free;
        mem_raddr = b1_q[RowW-1:0];
      end
      S_OTOP: begin
        mem_we    = otop_go;
        mem_waddr = t2_q[RowW-1:0];
      end
      S_OBOT: begin
        mem_we    = obot_go;
        mem_waddr = b2_q[RowW-1:0];
      end
      default: begin
        mem_re = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      span_mem[mem_waddr] <= col_q;
    end
    if (mem_re) begin
      rdata_q <= span_mem[mem_raddr];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ret_q          <= S_TOP;
      prev_top_q     <= '0;
      prev_bottom_q  <= '0;
      prev_empty_q   <= 1'b1;
      t1_q           <= EmptyTop;
      b1_q           <= EmptyBottom;
      t2_q           <= EmptyTop;
      b2_q           <= EmptyBottom;
      col_q          <= '0;
      xend_q         <= '0;
      row_q          <= '0;
      last_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      span_row_q     <= '0;
      span_x_start_q <= '0;
      span_x_end_q   <= '0;
      last_span_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            // new plane or empty previous column: nothing to close
            if (plane_start_i || prev_empty_q) begin
              t1_q <= EmptyTop;
              b1_q <= EmptyBottom;
            end else begin
              t1_q <= rptr_t'(prev_top_q);
              b1_q <= rptr_t'(prev_bottom_q);
            end
            if (empty_column_i) begin
              t2_q <= EmptyTop;
              b2_q <= EmptyBottom;
            end else begin
              t2_q <= top_in;
              b2_q <= bot_in;
            end
            col_q         <= column_i;
            xend_q        <= XW'(column_i - ColW'(1));
            // an inverted range is kept as given, it covers no rows later
            prev_top_q    <= top_in[5:0];
            prev_bottom_q <= bot_in[5:0];
            prev_empty_q  <= empty_column_i;
            state_q       <= S_TOP;
          end
        end
        S_TOP: begin
          if (!top_go) begin
            state_q <= S_BOT;
          end else if (out_free) begin
            row_q   <= t1_q[RowW-1:0];
            last_q  <= !more_after_top;
            t1_q    <= t1_inc;
            ret_q   <= S_TOP;
            state_q <= S_FETCH;
          end
        end
        S_BOT: begin
          if (!bot_go) begin
            state_q <= S_OTOP;
          end else if (out_free) begin
            row_q   <= b1_q[RowW-1:0];
            last_q  <= !more_after_bot;
            b1_q    <= b1_dec;
            ret_q   <= S_BOT;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          out_valid_q    <= 1'b1;
          span_row_q     <= row_q;
          span_x_start_q <= rdata_q[XW-1:0];
          span_x_end_q   <= xend_q;
          last_span_q    <= last_q;
          state_q        <= ret_q;
        end
        S_OTOP: begin
          if (otop_go) begin
            t2_q <= t2_q + rptr_t'(1);
          end else begin
            state_q <= S_OBOT;
          end
        end
        S_OBOT: begin
          if (obot_go) begin
            b2_q <= b2_q - rptr_t'(1);
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign span_row_o     = span_row_q;
  assign span_x_start_o = span_x_start_q;
  assign span_x_end_o   = span_x_end_q;
  assign last_span_o    = last_span_q;

  // a read is only issued when the output register will be free for it
  a_fetch_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> !out_valid_q)
    else $error("span fetch while output register busy");

  // every fetch presents a span in the next cycle
  a_fetch_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> out_valid_q)
    else $error("span fetch did not load the output register");

  // an accepted column starts the close walk
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_TOP))
    else $error("accepted column did not start the row walk");

  // memory is never read and written in the same cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re && mem_we))
    else $error("span start memory read and written together");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the column to row span converter: a short table of
// directed columns, then random planes and noise, every span checked in order
// against a behavioral tracker of the open rows or against the directed
// table's typed span or no-span check
module tb
  import crsc_pkg::*;
();

  // how each directed row is checked
  typedef enum logic [1:0] {
    BY_PREDICTOR,
    NO_SPAN,
    ONE_SPAN
  } dir_kind_e;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [XW-1:0]   x_start;
    logic [XW-1:0]   x_end;
    logic            last_span;
  } span_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [5:0]      top;
    logic [5:0]      bot;
    logic            empty;
    logic            pstart;
    dir_kind_e       kind;
    logic [RowW-1:0] srow;
    logic [XW-1:0]   sxs;
    logic [XW-1:0]   sxe;
  } dir_row_t;

  localparam int NUM_DIRECTED  = 25;
  localparam int RANDOM_ITEMS  = 245;
  localparam int HOLD_AT       = 100;
  localparam int HOLD_CYCLES   = 600;
  localparam int PAUSE_AT      = 180;
  localparam int SETTLE_CYCLES = 400;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [ColW-1:0] column;
  logic [5:0]      top_row;
  logic [5:0]      bottom_row;
  logic            empty_column;
  logic            plane_start;
  logic            out_valid;
  logic            out_stall;
  logic [RowW-1:0] span_row;
  logic [XW-1:0]   span_x_start;
  logic [XW-1:0]   span_x_end;
  logic            last_span;

  // tracker state: start column of every open row and the previous column
  logic [ColW-1:0] row_open_col [Rows];
  rptr_t           last_top;
  rptr_t           last_bottom;
  logic            last_empty;

  span_t    pending_spans [$];
  dir_row_t directed_cols [NUM_DIRECTED];

  int error_count;
  int items_sent;
  int spans_seen;
  int longest_burst;
  int holds_done;
  bit no_idle;
  bit hold_spans;

  column_to_row_span_converter_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .column_i       (column),
    .top_row_i      (top_row),
    .bottom_row_i   (bottom_row),
    .empty_column_i (empty_column),
    .plane_start_i  (plane_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .span_row_o     (span_row),
    .span_x_start_o (span_x_start),
    .span_x_end_o   (span_x_end),
    .last_span_o    (last_span)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int fit_row(input int r);
    return (r < 0) ? 0 : (r > int'(Rows) - 1) ? int'(Rows) - 1 : r;
  endfunction

  // close the rows that the previous column covered and this one does not,
  // top side going down then bottom side going up, and open the new rows
  task automatic track_column(input logic [ColW-1:0] col, input logic [5:0] top,
                              input logic [5:0] bot, input logic empty,
                              input logic pstart, input bit keep);
    rptr_t         t1, b1, t2, b2, top_c, bot_c;
    logic [XW-1:0] x_end;
    span_t         s;
    span_t         batch [$];
    top_c = (rptr_t'(top) > rptr_t'(Rows - 1)) ? rptr_t'(Rows - 1) : rptr_t'(top);
    bot_c = (rptr_t'(bot) > rptr_t'(Rows - 1)) ? rptr_t'(Rows - 1) : rptr_t'(bot);
    x_end = XW'(col - 1'b1);
    // a new plane or an empty previous column forgets the previous column
    if (pstart || last_empty) begin
      t1 = EmptyTop;
      b1 = EmptyBottom;
    end else begin
      t1 = last_top;
      b1 = last_bottom;
    end
    if (empty) begin
      t2 = EmptyTop;
      b2 = EmptyBottom;
    end else begin
      t2 = top_c;
      b2 = bot_c;
    end
    while (t1 < t2 && t1 <= b1) begin
      s.row       = t1[RowW-1:0];
      s.x_start   = row_open_col[t1[RowW-1:0]][XW-1:0];
      s.x_end     = x_end;
      s.last_span = 1'b0;
      batch.push_back(s);
      t1++;
    end
    while (b1 > b2 && b1 >= t1) begin
      s.row       = b1[RowW-1:0];
      s.x_start   = row_open_col[b1[RowW-1:0]][XW-1:0];
      s.x_end     = x_end;
      s.last_span = 1'b0;
      batch.push_back(s);
      b1--;
    end
    while (t2 < t1 && t2 <= b2) begin
      row_open_col[t2[RowW-1:0]] = col;
      t2++;
    end
    while (b2 > b1 && b2 >= t2) begin
      row_open_col[b2[RowW-1:0]] = col;
      b2--;
    end
    if (batch.size() > 0) begin
      s = batch.pop_back();
      s.last_span = 1'b1;
      batch.push_back(s);
    end
    if (batch.size() > longest_burst) longest_burst = batch.size();
    if (keep) begin
      foreach (batch[i]) pending_spans.push_back(batch[i]);
    end
    last_top    = top_c;
    last_bottom = bot_c;
    last_empty  = empty;
  endtask

  // present one column item, wait for it to be taken, then track it
  task automatic offer_column(input logic [ColW-1:0] col, input logic [5:0] top,
                              input logic [5:0] bot, input logic empty,
                              input logic pstart, input bit keep);
    int gap;
    // sender pause: let every span come out first
    if (items_sent == PAUSE_AT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_spans.size() != 0);
    end
    // long output hold-off while the sender keeps pushing
    if (items_sent == HOLD_AT) hold_spans = 1'b1;
    no_idle = (items_sent % 64) < 10 ||
              (items_sent >= HOLD_AT && items_sent < HOLD_AT + 40);
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    column       <= col;
    top_row      <= top;
    bottom_row   <= bot;
    empty_column <= empty;
    plane_start  <= pstart;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_column(col, top, bot, empty, pstart, keep);
    items_sent++;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    $display("%0t tb: span %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // stimulus: reset, directed table, random planes, drain
  initial begin : stimulus
    dir_row_t d;
    span_t    typed;
    int       x, top, bot, ncol, flaw;
    logic     e, p;

    // column, top, bottom, empty, new plane, check, typed span
    directed_cols[0]  = '{10'd0,    6'd0,  6'd63, 1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[1]  = '{10'd5,    6'd1,  6'd63, 1'b0, 1'b0, ONE_SPAN,     6'd0,  9'd0,   9'd4};
    directed_cols[2]  = '{10'd6,    6'd1,  6'd62, 1'b0, 1'b0, ONE_SPAN,     6'd63, 9'd0,   9'd5};
    directed_cols[3]  = '{10'd7,    6'd0,  6'd0,  1'b1, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};
    // column zero wraps the span end
    directed_cols[4]  = '{10'd0,    6'd20, 6'd30, 1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[5]  = '{10'd0,    6'd20, 6'd29, 1'b0, 1'b0, ONE_SPAN,     6'd30, 9'd0,   9'd511};
    // columns past the screen, inverted range
    directed_cols[6]  = '{10'd1023, 6'd25, 6'd29, 1'b0, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};
    directed_cols[7]  = '{10'd1023, 6'd40, 6'd10, 1'b0, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};
    directed_cols[8]  = '{10'd600,  6'd10, 6'd20, 1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    // new plane abandons the open rows
    directed_cols[9]  = '{10'd601,  6'd12, 6'd20, 1'b0, 1'b1, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[10] = '{10'd700,  6'd0,  6'd0,  1'b0, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};
    directed_cols[11] = '{10'd701,  6'd0,  6'd0,  1'b1, 1'b0, ONE_SPAN,     6'd0,  9'd188, 9'd188};
    directed_cols[12] = '{10'd800,  6'd63, 6'd63, 1'b0, 1'b1, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[13] = '{10'd801,  6'd62, 6'd63, 1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[14] = '{10'd802,  6'd63, 6'd63, 1'b0, 1'b0, ONE_SPAN,     6'd62, 9'd289, 9'd289};
    directed_cols[15] = '{10'd803,  6'd63, 6'd63, 1'b1, 1'b0, ONE_SPAN,     6'd63, 9'd288, 9'd290};
    // inverted range as the previous column
    directed_cols[16] = '{10'd10,   6'd5,  6'd3,  1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[17] = '{10'd11,   6'd3,  6'd5,  1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[18] = '{10'd12,   6'd3,  6'd5,  1'b1, 1'b1, NO_SPAN,      6'd0,  9'd0,   9'd0};
    // one side closes while the other side opens
    directed_cols[19] = '{10'd13,   6'd30, 6'd40, 1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[20] = '{10'd20,   6'd35, 6'd45, 1'b0, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};
    directed_cols[21] = '{10'd21,   6'd32, 6'd38, 1'b0, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};
    directed_cols[22] = '{10'd30,   6'd0,  6'd0,  1'b1, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};
    // full height plane, all rows close in one item
    directed_cols[23] = '{10'd512,  6'd0,  6'd63, 1'b0, 1'b0, NO_SPAN,      6'd0,  9'd0,   9'd0};
    directed_cols[24] = '{10'd513,  6'd0,  6'd0,  1'b1, 1'b0, BY_PREDICTOR, 6'd0,  9'd0,   9'd0};

    error_count   = 0;
    items_sent    = 0;
    spans_seen    = 0;
    longest_burst = 0;
    holds_done    = 0;
    no_idle       = 1'b0;
    hold_spans    = 1'b0;
    last_top      = EmptyBottom;
    last_bottom   = EmptyBottom;
    last_empty    = 1'b1;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    column        = '0;
    top_row       = '0;
    bottom_row    = '0;
    empty_column  = 1'b0;
    plane_start   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_cols[i]) begin
      d = directed_cols[i];
      offer_column(d.col, d.top, d.bot, d.empty, d.pstart, d.kind == BY_PREDICTOR);
      if (d.kind == ONE_SPAN) begin
        typed.row       = d.srow;
        typed.x_start   = d.sxs;
        typed.x_end     = d.sxe;
        typed.last_span = 1'b1;
        pending_spans.push_back(typed);
      end
    end

    // random part: mostly well-formed planes, some noise and broken planes
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_column(ColW'($urandom), 6'($urandom), 6'($urandom),
                     1'($urandom), 1'($urandom), 1'b1);
      end else begin
        x    = $urandom_range(0, 500);
        ncol = $urandom_range(1, 10);
        if ($urandom_range(0, 7) == 0) begin
          top = $urandom_range(0, 3);
          bot = $urandom_range(60, 63);
        end else begin
          top = $urandom_range(0, 63);
          bot = fit_row(top + int'($urandom_range(0, 6)));
        end
        for (int c = 0; c < ncol; c++) begin
          // flaws: inverted range, empty in mid plane, new plane in mid plane
          flaw = $urandom_range(0, 11);
          e    = (flaw == 1);
          p    = (c == 0) ? 1'($urandom_range(0, 1)) : (flaw == 2);
          offer_column(ColW'(x), 6'(flaw == 0 ? bot : top), 6'(flaw == 0 ? top : bot),
                       e, p, 1'b1);
          x   = x + (($urandom_range(0, 7) == 0) ? int'($urandom_range(2, 40)) : 1);
          top = fit_row(top + int'($urandom_range(0, 6)) - 3);
          bot = fit_row(bot + int'($urandom_range(0, 6)) - 3);
          if (bot < top) bot = top;
        end
        // closing empty column, now and then left out
        if ($urandom_range(0, 7) != 0) begin
          offer_column(ColW'(x), 6'($urandom), 6'($urandom), 1'b1,
                       1'($urandom_range(0, 1)), 1'b1);
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_spans.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d column items (%0d directed), %0d spans checked, longest burst %0d",
             items_sent, NUM_DIRECTED, spans_seen, longest_burst);
    $display("tb: %0d long output hold-offs, %0d mismatches", holds_done, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // span receiver: random stall per span, one long hold-off on request
  initial begin : span_sink
    int stall_len;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_spans) begin
        hold_spans = 1'b0;
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall_len = no_idle ? 0 : $urandom_range(0, 15);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // span checker: every taken span against the oldest expected one
  always @(posedge clk) begin : span_check
    span_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      spans_seen++;
      if (pending_spans.size() == 0) begin
        error_count++;
        $display("%0t tb: unexpected span, expected none, got row %0d start %0d end %0d",
                 $time, span_row, span_x_start, span_x_end);
      end else begin
        want = pending_spans.pop_front();
        if (want.row !== span_row) report_mismatch("row", 32'(want.row), 32'(span_row));
        if (want.x_start !== span_x_start)
          report_mismatch("x_start", 32'(want.x_start), 32'(span_x_start));
        if (want.x_end !== span_x_end)
          report_mismatch("x_end", 32'(want.x_end), 32'(span_x_end));
        if (want.last_span !== last_span)
          report_mismatch("last_span", 32'(want.last_span), 32'(last_span));
      end
    end
  end

endmodule
